[rtl/sorted_posting_semi_join_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the sorted posting semi-join
// Two checking forms, same cycle and next cycle, compiled away under SYNTH.
// ---------------------------------------------------------------------------
`ifndef SORTED_POSTING_SEMI_JOIN_ASSERT_SVH
`define SORTED_POSTING_SEMI_JOIN_ASSERT_SVH

`ifndef SYNTH
// The consequent must hold in the same cycle as the antecedent.
`define SPSJ_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("spsj assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define SPSJ_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("spsj assertion failed");
`else
`define SPSJ_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons)
`define SPSJ_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons)
`endif

`endif

[rtl/spsj_pkg.sv]
// ---------------------------------------------------------------------------
// spsj_pkg
// Types and constants shared by the sorted posting semi-join modules.
// ---------------------------------------------------------------------------
package spsj_pkg;

  localparam int MATCH_DEPTH = 4096;
  localparam int ADDR_W      = (MATCH_DEPTH > 1) ? $clog2(MATCH_DEPTH) : 1;
  localparam int CNT_W       = $clog2(MATCH_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(MATCH_DEPTH);

  // Decoupling queue between front and back.
  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // Item kinds.
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_POST = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [31:0] context_id;
    logic [31:0] entity_id;
    logic [15:0] score;
    logic        last;
  } in_item_t;

  typedef struct packed {
    logic [31:0] out_context;
    logic [31:0] out_entity;
    logic [15:0] out_score;
  } out_item_t;

  // Queue head as seen by the back end.
  typedef struct packed {
    logic     valid;
    logic     is_post;
    in_item_t item;
  } front_req_t;

  typedef enum logic {
    ST_IDLE,
    ST_CMP
  } back_st_t;

endpackage

[rtl/spsj_ram.sv]
// ---------------------------------------------------------------------------
// spsj_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
module spsj_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/spsj_front.sv]
// ---------------------------------------------------------------------------
// spsj_front
// Accepts input beats into a short queue and classifies the head item.
// ---------------------------------------------------------------------------
module spsj_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  spsj_pkg::in_item_t  in_item,
  input  logic                pop,
  output spsj_pkg::front_req_t req
);

  import spsj_pkg::*;

  `include "sorted_posting_semi_join_assert.svh"

  in_item_t       q_r [QDEPTH];
  logic [QAW-1:0] wp_r, wp_nxt;
  logic [QAW-1:0] hp_r, hp_nxt;
  logic [QCW-1:0] cnt_r, cnt_nxt;
  logic           push;
  logic           do_pop;

  assign busy   = (cnt_r == QCW'(QDEPTH));
  assign push   = start && !busy;
  assign do_pop = pop && (cnt_r != '0);

  always_comb begin
    wp_nxt  = push   ? wp_r + 1'b1 : wp_r;
    hp_nxt  = do_pop ? hp_r + 1'b1 : hp_r;
    cnt_nxt = cnt_r;
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      hp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      hp_r  <= hp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= in_item;
    end
  end

  always_comb begin
    req.valid   = (cnt_r != '0);
    req.item    = q_r[hp_r];
    req.is_post = (q_r[hp_r].kind == KIND_POST);
  end

  `SPSJ_ASSERT_NOW(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= QCW'(QDEPTH))
  `SPSJ_ASSERT_NXT(a_cnt_grow, clk, rst_n, push && !do_pop, cnt_r == $past(cnt_r) + 1'b1)
  `SPSJ_ASSERT_NXT(a_cnt_fall, clk, rst_n, do_pop && !push, cnt_r == $past(cnt_r) - 1'b1)

endmodule

[rtl/spsj_back.sv]
// ---------------------------------------------------------------------------
// spsj_back
// Holds the match store and runs the merge walk for each posting.
// ---------------------------------------------------------------------------
module spsj_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  spsj_pkg::front_req_t req,
  output logic                 pop,
  output logic                 out_valid,
  output spsj_pkg::out_item_t  out_item
);

  import spsj_pkg::*;

  `include "sorted_posting_semi_join_assert.svh"

  back_st_t         state_r, state_nxt;
  logic [CNT_W-1:0] lc_r, lc_nxt;
  logic [CNT_W-1:0] rp_r, rp_nxt;
  logic [CNT_W-1:0] rp_inc;
  in_item_t         cur_r, cur_nxt;
  logic             ov_r, ov_nxt;
  out_item_t        out_r, out_nxt;

  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic              re;
  logic [ADDR_W-1:0] raddr;
  logic [31:0]       rdata;

  spsj_ram #(
    .WIDTH (32),
    .DEPTH (MATCH_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (req.item.context_id),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rp_inc = rp_r + 1'b1;

  always_comb begin
    state_nxt = state_r;
    lc_nxt    = lc_r;
    rp_nxt    = rp_r;
    cur_nxt   = cur_r;
    ov_nxt    = 1'b0;
    out_nxt   = out_r;
    pop       = 1'b0;
    we        = 1'b0;
    waddr     = lc_r[ADDR_W-1:0];
    re        = 1'b0;
    raddr     = rp_r[ADDR_W-1:0];
    unique case (state_r)
      ST_IDLE: begin
        if (req.valid) begin
          pop     = 1'b1;
          cur_nxt = req.item;
          if (!req.is_post) begin
            // A load beyond the store's capacity is dropped.
            if (lc_r < DEPTH_CNT) begin
              we     = 1'b1;
              lc_nxt = lc_r + 1'b1;
            end
          end else if (rp_r < lc_r) begin
            re        = 1'b1;
            state_nxt = ST_CMP;
          end else if (req.item.last) begin
            lc_nxt = '0;
            rp_nxt = '0;
          end
        end
      end
      ST_CMP: begin
        // rdata holds the stored id at rp_r, which is below lc_r here.
        if (rdata < cur_r.context_id) begin
          rp_nxt = rp_inc;
          if (rp_inc < lc_r) begin
            re    = 1'b1;
            raddr = rp_inc[ADDR_W-1:0];
          end else begin
            state_nxt = ST_IDLE;
            if (cur_r.last) begin
              lc_nxt = '0;
              rp_nxt = '0;
            end
          end
        end else begin
          state_nxt           = ST_IDLE;
          ov_nxt              = (rdata == cur_r.context_id);
          out_nxt.out_context = cur_r.context_id;
          out_nxt.out_entity  = cur_r.entity_id;
          out_nxt.out_score   = cur_r.score;
          if (cur_r.last) begin
            lc_nxt = '0;
            rp_nxt = '0;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      lc_r    <= '0;
      rp_r    <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      lc_r    <= lc_nxt;
      rp_r    <= rp_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = ov_r;
  assign out_item  = out_r;

  `SPSJ_ASSERT_NOW(a_rp_le_lc, clk, rst_n, 1'b1, rp_r <= lc_r)
  `SPSJ_ASSERT_NOW(a_lc_bound, clk, rst_n, 1'b1, lc_r <= DEPTH_CNT)
  `SPSJ_ASSERT_NOW(a_cmp_in_range, clk, rst_n, state_r == ST_CMP, rp_r < lc_r)
  `SPSJ_ASSERT_NXT(a_out_after_cmp, clk, rst_n, state_r == ST_IDLE, !out_valid)

endmodule

[rtl/sorted_posting_semi_join.sv]
// ---------------------------------------------------------------------------
// sorted_posting_semi_join
// Merge intersection of sorted entity postings against a loaded id list.
// ---------------------------------------------------------------------------
//
//  Channel  Handshake        Payload                     Direction
//  -------  ---------------  --------------------------  ---------
//  input    start / busy     in_item  (spsj_pkg)         in
//  result   out_valid strobe out_item (spsj_pkg)         out
//
// A load beat is handled in the back end's idle state. A posting is handled
// there without a walk when the read pointer stands at the load count;
// otherwise the compare state steps the pointer over each stored id below
// the context and stops on the first one not below it, or when the walk
// runs off the end of the list, reading the store through its single read
// port. Pointer steps over a query total at most the number of loaded ids.
// Reset is synchronous and active low; it empties the queue and clears the
// load count and the read pointer. The store keeps its contents.
// busy rises only when the two-beat queue is full. A result is shown for
// exactly one cycle, in the cycle after its comparison finishes.
//
module sorted_posting_semi_join (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  spsj_pkg::in_item_t  in_item,
  output logic                out_valid,
  output spsj_pkg::out_item_t out_item
);

  import spsj_pkg::*;

  // The front end queues accepted beats and tags each as a load or a
  // posting; the back end pops them one at a time.
  front_req_t req;
  logic       pop;

  spsj_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_item (in_item),
    .pop     (pop),
    .req     (req)
  );

  // The back end appends loads to the store and walks the read pointer for
  // postings, raising the result strobe on an exact match.
  spsj_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .pop       (pop),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for sorted_posting_semi_join
// Drives load and posting beats over the start/busy port and keeps its own
// merge predictor of the id store. Every strobed result is compared against
// the oldest outstanding hit. The run has two parts: a directed table, then
// random queries under three sender gap settings.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import spsj_pkg::*;

  // The run is ended by force well beyond the slowest legal run. That run is
  // about sixteen hundred beats, plus the pointer walks and the final drain.
  localparam int CYCLE_LIMIT = 500000;
  localparam int REPORT_CAP  = 40;

  // A directed row either states its expected result outright or leaves it
  // to the predictor.
  localparam logic EXP_MODEL = 1'b0;
  localparam logic EXP_TYPED = 1'b1;
  localparam logic RES_NONE  = 1'b0;
  localparam logic RES_ONE   = 1'b1;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;

  // Predictor state: a private copy of the id store and of the two counters.
  logic [31:0]      match_ids [MATCH_DEPTH];
  logic [CNT_W-1:0] n_loaded  = '0;
  logic [CNT_W-1:0] merge_pos = '0;

  // Hits that the block still owes, oldest first.
  out_item_t pending_hits [$];

  int mismatches = 0;
  int beats_sent = 0;
  int gap_pct    = 0;
  int cycles     = 0;

  typedef struct packed {
    logic        kind;
    logic [31:0] ctx;
    logic [31:0] ent;
    logic [15:0] scr;
    logic        last;
    logic        typed;
    logic        hit;
    logic [31:0] w_ctx;
    logic [31:0] w_ent;
    logic [15:0] w_scr;
  } dir_row_t;

  localparam int DIR_ROWS = 22;

  // The directed part. Rows marked typed carry a result that can be read
  // straight off the rules; the rest are left to the predictor.
  dir_row_t dir_tab [DIR_ROWS] = '{
    // A posting straight after reset meets an empty store and passes nothing.
    '{KIND_POST, 32'd5, 32'h11, 16'h1, 1'b0,
      EXP_TYPED, RES_NONE, 32'd0, 32'd0, 16'd0},
    // Load the lowest id twice, so that the duplicate is stored as well.
    '{KIND_LOAD, 32'd0, 32'hFFFF_FFFF, 16'hFFFF, 1'b0,
      EXP_MODEL, RES_NONE, 32'd0, 32'd0, 16'd0},
    '{KIND_LOAD, 32'd0, 32'd0, 16'd0, 1'b0,
      EXP_MODEL, RES_NONE, 32'd0, 32'd0, 16'd0},
    // The last flag on a load must not end the query.
    '{KIND_LOAD, 32'd7, 32'd0, 16'd0, 1'b1,
      EXP_MODEL, RES_NONE, 32'd0, 32'd0, 16'd0},
    '{KIND_LOAD, 32'hFFFF_FFFF, 32'd0, 16'd0, 1'b0,
      EXP_MODEL, RES_NONE, 32'd0, 32'd0, 16'd0},
    '{KIND_LOAD, 32'hFFFF_FFFF, 32'd0, 16'd0, 1'b0,
      EXP_MODEL, RES_NONE, 32'd0, 32'd0, 16'd0},
    // Lowest context with the largest entity and score, then all zeros.
    '{KIND_POST, 32'd0, 32'hFFFF_FFFF, 16'hFFFF, 1'b0,
      EXP_TYPED, RES_ONE, 32'd0, 32'hFFFF_FFFF, 16'hFFFF},
    '{KIND_POST, 32'd0, 32'd0, 16'd0, 1'b0,
      EXP_TYPED, RES_ONE, 32'd0, 32'd0, 16'd0},
    // The pointer steps over both zeros and stops on the 7, which differs.
    '{KIND_POST, 32'd3, 32'h33, 16'h3, 1'b0,
      EXP_TYPED, RES_NONE, 32'd0, 32'd0, 16'd0},
    // Out of order: the context is below the stored id at the pointer.
    '{KIND_POST, 32'd1, 32'h44, 16'h4, 1'b0,
      EXP_MODEL, RES_NONE, 32'd0, 32'd0, 16'd0},
    '{KIND_POST, 32'd7, 32'hCAFE_0007, 16'h5A5A, 1'b0,
      EXP_MODEL, RES_NONE, 32'd0, 32'd0, 16'd0},
    // A load after postings is appended behind the largest ids, which leaves
    // the store out of order.
    '{KIND_LOAD, 32'd10, 32'h55, 16'h5, 1'b0,
      EXP_MODEL, RES_NONE, 32'd0, 32'd0, 16'd0},
    '{KIND_POST, 32'd8, 32'h66, 16'h6, 1'b0,
      EXP_MODEL, RES_NONE, 32'd0, 32'd0, 16'd0},
    '{KIND_POST, 32'd10, 32'h77, 16'h7, 1'b0,
      EXP_MODEL, RES_NONE, 32'd0, 32'd0, 16'd0},
    // The largest context matches on the final posting, which then clears
    // both counters.
    '{KIND_POST, 32'hFFFF_FFFF, 32'h1234_5678, 16'hA5A5, 1'b1,
      EXP_TYPED, RES_ONE, 32'hFFFF_FFFF, 32'h1234_5678, 16'hA5A5},
    '{KIND_POST, 32'hFFFF_FFFF, 32'd0, 16'd0, 1'b0,
      EXP_TYPED, RES_NONE, 32'd0, 32'd0, 16'd0},
    '{KIND_LOAD, 32'd100, 32'd0, 16'd0, 1'b0,
      EXP_MODEL, RES_NONE, 32'd0, 32'd0, 16'd0},
    '{KIND_LOAD, 32'd200, 32'd0, 16'd0, 1'b0,
      EXP_MODEL, RES_NONE, 32'd0, 32'd0, 16'd0},
    '{KIND_POST, 32'd100, 32'h8000_0000, 16'h8000, 1'b0,
      EXP_MODEL, RES_NONE, 32'd0, 32'd0, 16'd0},
    '{KIND_POST, 32'd150, 32'h0000_0001, 16'h0001, 1'b0,
      EXP_MODEL, RES_NONE, 32'd0, 32'd0, 16'd0},
    '{KIND_POST, 32'd200, 32'h7FFF_FFFF, 16'h7FFF, 1'b1,
      EXP_MODEL, RES_NONE, 32'd0, 32'd0, 16'd0},
    // The query has just ended, so the store counts as empty again.
    '{KIND_POST, 32'd200, 32'd0, 16'd0, 1'b1,
      EXP_TYPED, RES_NONE, 32'd0, 32'd0, 16'd0}
  };

  sorted_posting_semi_join i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog: a stuck handshake or a missing result ends up here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= REPORT_CAP) $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // Merge step of the predictor. A load is appended unless the store is full.
  // A posting moves the pointer past smaller ids and passes on an equal one;
  // the last flag on a posting then restarts both counters.
  function automatic bit semi_join_step(input in_item_t beat, output out_item_t res);
    bit found;
    found = 1'b0;
    res   = '0;
    if (beat.kind == KIND_LOAD) begin
      if (n_loaded < DEPTH_CNT) begin
        match_ids[n_loaded[ADDR_W-1:0]] = beat.context_id;
        n_loaded++;
      end
      return 1'b0;
    end
    while (merge_pos < n_loaded && match_ids[merge_pos[ADDR_W-1:0]] < beat.context_id)
      merge_pos++;
    if (merge_pos < n_loaded && match_ids[merge_pos[ADDR_W-1:0]] == beat.context_id) begin
      found           = 1'b1;
      res.out_context = beat.context_id;
      res.out_entity  = beat.entity_id;
      res.out_score   = beat.score;
    end
    if (beat.last) begin
      n_loaded  = '0;
      merge_pos = '0;
    end
    return found;
  endfunction

  function automatic in_item_t beat_of(input logic kind, input logic [31:0] ctx,
                                       input logic [31:0] ent, input logic [15:0] scr,
                                       input logic last);
    in_item_t beat;
    beat.kind       = kind;
    beat.context_id = ctx;
    beat.entity_id  = ent;
    beat.score      = scr;
    beat.last       = last;
    return beat;
  endfunction

  // Offers one beat, with random idle cycles in front of it, and waits until
  // the block takes it. The beat is taken at the edge where start is high and
  // busy is low; the expected hit is queued at that point.
  task automatic send_beat(input in_item_t beat, input bit typed = 1'b0,
                           input bit want_hit = 1'b0, input out_item_t want = '0);
    out_item_t res;
    bit        got_hit;
    while ($urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= beat;
    do @(posedge clk); while (busy);
    beats_sent++;
    got_hit = semi_join_step(beat, res);
    if (typed) begin
      got_hit = want_hit;
      res     = want;
    end
    if (got_hit) pending_hits = {pending_hits, res};
  endtask

  // Holds the sender off until every outstanding hit has come back.
  task automatic hold_until_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending_hits.size() != 0);
  endtask

  // One random query. Most are well formed: a sorted id list followed by
  // sorted postings, about half of which hit a stored id, ended by a last
  // posting. The rest break the rules: unsorted ids or postings, loads slipped
  // in between postings, an early last, or a query left open.
  task automatic random_query();
    int unsigned ids [$];
    int unsigned ctxs [$];
    int unsigned base;
    int          n_ids;
    int          n_posts;
    int          shape;
    int          pick;
    bit          dense;
    bit          fin;
    shape = $urandom_range(0, 99);
    n_ids = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 150) : $urandom_range(0, 20);
    dense = 1'($urandom_range(0, 1));
    base  = $urandom;
    for (int i = 0; i < n_ids; i++)
      ids = {ids, (dense ? base + $urandom_range(0, 2 * n_ids + 2) : $urandom)};
    if (shape < 90) ids.sort();
    foreach (ids[i])
      send_beat(beat_of(KIND_LOAD, ids[i], $urandom, 16'($urandom),
                        1'($urandom_range(0, 1))));
    n_posts = $urandom_range(1, 20);
    for (int i = 0; i < n_posts; i++) begin
      pick = $urandom_range(0, 3);
      if (ids.size() != 0 && pick < 2)
        ctxs = {ctxs, ids[$urandom_range(0, ids.size() - 1)]};
      else if (ids.size() != 0 && pick == 2)
        ctxs = {ctxs, ids[$urandom_range(0, ids.size() - 1)] + $urandom_range(0, 2) - 1};
      else
        ctxs = {ctxs, (dense ? base + $urandom_range(0, 2 * n_ids + 2) : $urandom)};
    end
    if (shape < 85) ctxs.sort();
    foreach (ctxs[i]) begin
      if (shape >= 80 && $urandom_range(0, 5) == 0)
        send_beat(beat_of(KIND_LOAD, base + $urandom_range(0, 2 * n_ids + 2), $urandom,
                          16'($urandom), 1'b0));
      if (i == ctxs.size() - 1) fin = (shape < 95);
      else fin = (shape >= 90 && $urandom_range(0, 7) == 0);
      send_beat(beat_of(KIND_POST, ctxs[i], $urandom, 16'($urandom), fin));
    end
  endtask

  // Result checker. The block cannot be held off, so every strobe is a beat
  // that must match the oldest outstanding hit.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_hits.size() == 0) begin
        flag_mismatch($sformatf("unexpected result ctx=%h ent=%h score=%h",
                                out_item.out_context, out_item.out_entity,
                                out_item.out_score));
      end else begin
        if (out_item.out_context !== pending_hits[0].out_context)
          flag_mismatch($sformatf("out_context %h, expected %h",
                                  out_item.out_context, pending_hits[0].out_context));
        if (out_item.out_entity !== pending_hits[0].out_entity)
          flag_mismatch($sformatf("out_entity %h, expected %h",
                                  out_item.out_entity, pending_hits[0].out_entity));
        if (out_item.out_score !== pending_hits[0].out_score)
          flag_mismatch($sformatf("out_score %h, expected %h",
                                  out_item.out_score, pending_hits[0].out_score));
        void'(pending_hits.pop_front());
      end
    end
  end

  initial begin
    out_item_t want;
    int        goal;
    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_item <= '0;
    repeat (3) @(posedge clk);
    rst_n   <= 1'b1;

    // Directed table, under the first gap setting.
    gap_pct = 34;
    foreach (dir_tab[r]) begin
      want.out_context = dir_tab[r].w_ctx;
      want.out_entity  = dir_tab[r].w_ent;
      want.out_score   = dir_tab[r].w_scr;
      send_beat(beat_of(dir_tab[r].kind, dir_tab[r].ctx, dir_tab[r].ent,
                        dir_tab[r].scr, dir_tab[r].last),
                dir_tab[r].typed, dir_tab[r].hit, want);
    end
    hold_until_drained();

    // Random queries: a rare sender gap, a frequent one, then none at all.
    goal = beats_sent + 520;
    while (beats_sent < goal) random_query();
    hold_until_drained();

    gap_pct = 79;
    goal    = beats_sent + 520;
    while (beats_sent < goal) random_query();
    hold_until_drained();

    gap_pct = 0;
    goal    = beats_sent + 520;
    while (beats_sent < goal) random_query();
    hold_until_drained();

    // Let any walk still in progress finish, so that a stray result shows.
    repeat (3 * MATCH_DEPTH + 16) @(posedge clk);

    if (mismatches == 0 && pending_hits.size() == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

endmodule
